### rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Types and constants shared by the conveyor transfer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

    localparam logic [15:0] PULSE_TICKS_RESET = 16'd200;

    typedef enum logic [1:0] {
        REQ_SCAN  = 2'd0,
        REQ_START = 2'd1,
        REQ_CALIB = 2'd2,
        REQ_SPEED = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        LEVER_STOP = 2'd0,
        LEVER_FWD  = 2'd1,
        LEVER_BACK = 2'd2
    } lever_t;

    typedef enum logic [2:0] {
        RUN_IDLE     = 3'd0,
        RUN_WAIT_OBJ = 3'd1,
        RUN_PUSH     = 3'd2,
        RUN_OUT      = 3'd3,
        RUN_RETRACT  = 3'd4,
        RUN_CARRY    = 3'd5
    } run_state_t;

    typedef enum logic [2:0] {
        CAL_IDLE      = 3'd0,
        CAL_BELT_ONE  = 3'd1,
        CAL_BELT_TWO  = 3'd2,
        CAL_LEVER_OUT = 3'd3,
        CAL_LEVER_CHK = 3'd4,
        CAL_LEVER_IN  = 3'd5
    } calib_state_t;

    typedef enum logic [3:0] {
        MSG_NONE        = 4'd0,
        MSG_PAUSED      = 4'd1,
        MSG_DETECTED    = 4'd2,
        MSG_XFER_OUT    = 4'd3,
        MSG_MOVED       = 4'd4,
        MSG_IN_FAST     = 4'd5,
        MSG_XFER_IN     = 4'd6,
        MSG_TRANSIT     = 4'd7,
        MSG_ARRIVED     = 4'd8,
        MSG_TEST_BELT1  = 4'd9,
        MSG_TEST_BELT2  = 4'd10,
        MSG_TEST_OUT    = 4'd11,
        MSG_TEST_IN     = 4'd12,
        MSG_CAL_DONE    = 4'd13,
        MSG_FAST        = 4'd14,
        MSG_SLOW        = 4'd15
    } message_t;

    typedef struct packed {
        req_type_t req_type;
        logic      switch_on;
        logic      cube_at_start;
        logic      lever_home;
        logic      lever_out;
        logic      cube_at_end;
    } cts_item_t;

    typedef struct packed {
        run_state_t   run_state;
        calib_state_t calib_state;
        logic         calib_active;
        logic         run_enabled;
        logic         paused;
        logic         fast;
        logic         belt_one;
        logic         belt_two;
        lever_t       lever;
        logic [16:0]  pulse_count;
    } cts_state_t;

    typedef struct packed {
        logic         belt_one_run;
        logic         belt_two_run;
        lever_t       lever_drive;
        run_state_t   run_step;
        calib_state_t calib_step;
        message_t     message;
    } cts_result_t;

endpackage

`default_nettype wire

### rtl/cts_in_if.sv
// ----------------------------------------------------------------------------
// cts_in_if
// Request channel: scan ticks and switch events with sensor levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface cts_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic       switch_on;
    logic       cube_at_start;
    logic       lever_home;
    logic       lever_out;
    logic       cube_at_end;

    modport source (
        output valid, req_type, switch_on, cube_at_start, lever_home, lever_out,
               cube_at_end,
        input  ready
    );

    modport sink (
        input  valid, req_type, switch_on, cube_at_start, lever_home, lever_out,
               cube_at_end,
        output ready
    );
endinterface

`default_nettype wire

### rtl/cts_out_if.sv
// ----------------------------------------------------------------------------
// cts_out_if
// Response channel: motor drives, sequence states and message code.
// ----------------------------------------------------------------------------
`default_nettype none

interface cts_out_if;
    logic       valid;
    logic       ready;
    logic       belt_one_run;
    logic       belt_two_run;
    logic [1:0] lever_drive;
    logic [2:0] run_step;
    logic [2:0] calib_step;
    logic [3:0] message;

    modport source (
        output valid, belt_one_run, belt_two_run, lever_drive, run_step,
               calib_step, message,
        input  ready
    );

    modport sink (
        input  valid, belt_one_run, belt_two_run, lever_drive, run_step,
               calib_step, message,
        output ready
    );
endinterface

`default_nettype wire

### rtl/cts_step.sv
// ----------------------------------------------------------------------------
// cts_step
// Next-state and response logic for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_step
    import cts_pkg::*;
(
    input  wire cts_state_t  cur,
    input  wire cts_item_t   item,
    input  wire logic [15:0] pulse_ticks,
    output cts_state_t       nxt,
    output cts_result_t      result
);

    logic [15:0] pulse_len;
    logic [16:0] pulse_end;
    logic [16:0] cnt_inc;
    logic        pulse_on;
    logic        pulse_done;
    logic        cube_start;
    logic        home;
    logic        cube_end;
    message_t    msg;

    always_comb
    begin
        pulse_len  = (pulse_ticks == 16'd0) ? 16'd1 : pulse_ticks;
        pulse_end  = {pulse_len, 1'b0};
        cnt_inc    = cur.pulse_count + 17'd1;
        pulse_on   = cur.pulse_count < {1'b0, pulse_len};
        pulse_done = cnt_inc >= pulse_end;
    end

    always_comb
    begin
        nxt        = cur;
        msg        = MSG_NONE;
        cube_start = ~item.cube_at_start;
        home       = ~item.lever_home;
        cube_end   = ~item.cube_at_end;

        case (item.req_type)
            REQ_START:
            begin
                if (item.switch_on)
                begin
                    if (cur.paused)
                        nxt.paused = 1'b0;
                    else
                        nxt.run_state = RUN_WAIT_OBJ;
                    nxt.run_enabled = 1'b1;
                end
                else
                begin
                    nxt.run_enabled = 1'b0;
                    nxt.paused      = 1'b1;
                    nxt.belt_one    = 1'b0;
                    nxt.belt_two    = 1'b0;
                    nxt.lever       = LEVER_STOP;
                    msg             = MSG_PAUSED;
                end
            end
            REQ_CALIB:
            begin
                nxt.calib_active = item.switch_on;
                if (item.switch_on)
                begin
                    nxt.calib_state = CAL_BELT_ONE;
                    nxt.pulse_count = '0;
                end
            end
            REQ_SPEED:
            begin
                nxt.fast = item.switch_on;
                msg      = item.switch_on ? MSG_FAST : MSG_SLOW;
            end
            default:
            begin
                // belt one stops on object detect before any sequence step
                if (cur.run_state == RUN_WAIT_OBJ && cube_start)
                    nxt.belt_one = 1'b0;

                if (cur.calib_active)
                begin
                    case (cur.calib_state)
                        CAL_IDLE:
                        begin
                            nxt.belt_one = 1'b0;
                            nxt.belt_two = 1'b0;
                            nxt.lever    = LEVER_STOP;
                        end
                        CAL_BELT_ONE, CAL_BELT_TWO:
                        begin
                            if (cur.pulse_count == 17'd0)
                                msg = (cur.calib_state == CAL_BELT_ONE) ?
                                      MSG_TEST_BELT1 : MSG_TEST_BELT2;
                            if (cur.calib_state == CAL_BELT_ONE)
                                nxt.belt_one = pulse_on;
                            else
                                nxt.belt_two = pulse_on;
                            if (pulse_done)
                            begin
                                nxt.pulse_count = '0;
                                nxt.calib_state = (cur.calib_state == CAL_BELT_ONE) ?
                                                  CAL_BELT_TWO : CAL_LEVER_OUT;
                            end
                            else
                            begin
                                nxt.pulse_count = cnt_inc;
                            end
                        end
                        CAL_LEVER_OUT:
                        begin
                            msg          = MSG_TEST_OUT;
                            nxt.belt_two = 1'b0;
                            if (!item.lever_out)
                                nxt.lever = LEVER_FWD;
                            else
                            begin
                                nxt.lever       = LEVER_STOP;
                                nxt.calib_state = CAL_LEVER_CHK;
                            end
                        end
                        CAL_LEVER_CHK:
                        begin
                            if (item.lever_out)
                                nxt.calib_state = CAL_LEVER_IN;
                        end
                        CAL_LEVER_IN:
                        begin
                            msg = MSG_TEST_IN;
                            if (!home)
                                nxt.lever = LEVER_BACK;
                            else
                            begin
                                nxt.lever        = LEVER_STOP;
                                nxt.calib_state  = CAL_IDLE;
                                nxt.calib_active = 1'b0;
                                msg              = MSG_CAL_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (cur.run_enabled && !cur.paused)
                begin
                    case (cur.run_state)
                        RUN_IDLE:
                        begin
                            nxt.belt_one = 1'b0;
                            nxt.belt_two = 1'b0;
                            nxt.lever    = LEVER_STOP;
                        end
                        RUN_WAIT_OBJ:
                        begin
                            if (cube_start)
                            begin
                                nxt.belt_two  = 1'b1;
                                nxt.run_state = RUN_PUSH;
                                msg           = MSG_DETECTED;
                            end
                            else
                            begin
                                nxt.belt_one = 1'b1;
                                nxt.belt_two = 1'b0;
                                nxt.lever    = LEVER_STOP;
                            end
                        end
                        RUN_PUSH:
                        begin
                            if (!item.lever_out)
                            begin
                                nxt.lever    = LEVER_FWD;
                                nxt.belt_two = 1'b1;
                            end
                            else
                            begin
                                nxt.lever     = LEVER_STOP;
                                nxt.run_state = RUN_OUT;
                                msg           = MSG_XFER_OUT;
                            end
                        end
                        RUN_OUT:
                        begin
                            if (item.lever_out)
                            begin
                                nxt.run_state = RUN_RETRACT;
                                msg           = MSG_MOVED;
                            end
                        end
                        RUN_RETRACT:
                        begin
                            if (!home)
                                nxt.lever = LEVER_BACK;
                            else
                            begin
                                nxt.lever = LEVER_STOP;
                                if (cur.fast)
                                begin
                                    nxt.run_state = RUN_WAIT_OBJ;
                                    msg           = MSG_IN_FAST;
                                end
                                else
                                begin
                                    nxt.run_state = RUN_CARRY;
                                    msg           = MSG_XFER_IN;
                                end
                            end
                        end
                        RUN_CARRY:
                        begin
                            nxt.belt_two = 1'b1;
                            msg          = MSG_TRANSIT;
                            if (cube_end)
                            begin
                                nxt.belt_two  = 1'b0;
                                nxt.run_state = RUN_WAIT_OBJ;
                                msg           = MSG_ARRIVED;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    nxt.belt_one = 1'b0;
                    nxt.belt_two = 1'b0;
                    nxt.lever    = LEVER_STOP;
                end
            end
        endcase

        result.belt_one_run = nxt.belt_one;
        result.belt_two_run = nxt.belt_two;
        result.lever_drive  = nxt.lever;
        result.run_step     = nxt.run_state;
        result.calib_step   = nxt.calib_state;
        result.message      = msg;
    end

endmodule

`default_nettype wire

### rtl/conveyor_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// conveyor_transfer_sequencer
// Run and calibration sequencer for two belts and a transfer lever.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one transaction per scan tick or switch event (start,
//   calibration, speed) with the four raw sensor levels. rsp returns one
//   transaction per request: latched belt and lever drives, run and
//   calibration step, and a message code.
//   The request is captured in an input register; the sequencer logic then
//   updates its state and loads the response register once rsp can take it.
//   rsp valid comes from the response register, so each request passes the
//   input and response registers in turn; throughput is one transaction per
//   cycle while rsp does not stall, set by the single state update per cycle.
//   cfg_we/cfg_data write pulse_ticks, the on and off half length of a
//   calibration motor pulse in scan ticks; write it only while idle.
//   Reset stops all drives, clears both sequences and flags, and sets
//   pulse_ticks to 200. When rsp stalls, the held response and one more
//   request in the input register are kept; cmd.ready drops until rsp
//   drains, and nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module conveyor_transfer_sequencer
    import cts_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    cts_in_if.sink      cmd,
    cts_out_if.source   rsp,
    input  wire         cfg_we,
    input  wire  [15:0] cfg_data
);

    logic        item_valid_reg;
    cts_item_t   item_reg;
    logic        rsp_valid_reg;
    cts_result_t rsp_reg;
    cts_state_t  state_reg;
    cts_state_t  state_next;
    cts_result_t rsp_next;
    logic [15:0] pulse_ticks_reg;
    logic        advance;
    logic        cmd_take;

    assign advance  = item_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready = !item_valid_reg || advance;
    assign cmd_take = cmd.valid && cmd.ready;

    cts_step u_step (
        .cur         (state_reg),
        .item        (item_reg),
        .pulse_ticks (pulse_ticks_reg),
        .nxt         (state_next),
        .result      (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pulse_ticks_reg <= PULSE_TICKS_RESET;
        else if (cfg_we)
            pulse_ticks_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (cmd_take)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            item_reg.req_type      <= req_type_t'(cmd.req_type);
            item_reg.switch_on     <= cmd.switch_on;
            item_reg.cube_at_start <= cmd.cube_at_start;
            item_reg.lever_home    <= cmd.lever_home;
            item_reg.lever_out     <= cmd.lever_out;
            item_reg.cube_at_end   <= cmd.cube_at_end;
        end
        if (advance)
            rsp_reg <= rsp_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.belt_one_run = rsp_reg.belt_one_run;
    assign rsp.belt_two_run = rsp_reg.belt_two_run;
    assign rsp.lever_drive  = rsp_reg.lever_drive;
    assign rsp.run_step     = rsp_reg.run_step;
    assign rsp.calib_step   = rsp_reg.calib_step;
    assign rsp.message      = rsp_reg.message;

endmodule

`default_nettype wire

### verif/conveyor_transfer_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conveyor_transfer_sequencer_test
// Self-checking bench for the belt and lever sequencer. Scan ticks and
// switch events go in over the cmd channel, and each is predicted against
// a local model of the run and calibration sequences. Each rsp transaction
// is compared field by field with the oldest prediction. A directed part
// walks the run cycle, pause and resume, a full calibration and the pulse
// length extremes. Random phases with biased sensor levels and several
// pulse lengths follow, under bursty input and a stalling output.
// ----------------------------------------------------------------------------

module conveyor_transfer_sequencer_test;
    import cts_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 137;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    cts_in_if  cmd_if ();
    cts_out_if rsp_if ();

    conveyor_transfer_sequencer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_if),
        .rsp      (rsp_if),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    // local copy of the sequencer state
    run_state_t   seq_run   = RUN_IDLE;
    calib_state_t seq_cal   = CAL_IDLE;
    logic         cal_on    = 1'b0;
    logic         run_on    = 1'b0;
    logic         pause_on  = 1'b0;
    logic         fast_on   = 1'b0;
    logic         belt1     = 1'b0;
    logic         belt2     = 1'b0;
    lever_t       lever     = LEVER_STOP;
    logic [16:0]  pulse_cnt = '0;
    logic [15:0]  pulse_len = PULSE_TICKS_RESET;

    cts_result_t status_forecast[$];
    int          fails = 0;
    int          burst_left = 0;
    int          hold_requests = 0;
    bit          tx_gaps = 1'b0;
    bit          rx_stalls = 1'b0;

    function automatic void stop_drives();
        belt1 = 1'b0;
        belt2 = 1'b0;
        lever = LEVER_STOP;
    endfunction

    // One scan of a timed belt pulse; returns 1 once the off half is over.
    function automatic logic pulse_done(input logic [16:0] half, output logic drive);
        drive = (pulse_cnt < half);
        pulse_cnt = pulse_cnt + 17'd1;
        if (pulse_cnt >= (half << 1))
        begin
            pulse_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic cts_result_t next_status(input cts_item_t item);
        message_t    msg;
        logic        cube_here;
        logic        at_home;
        logic        fully_out;
        logic        arrived;
        logic [16:0] half;
        cts_result_t res;
        msg       = MSG_NONE;
        cube_here = !item.cube_at_start;
        at_home   = !item.lever_home;
        fully_out = item.lever_out;
        arrived   = !item.cube_at_end;
        half      = (pulse_len == 16'd0) ? 17'd1 : {1'b0, pulse_len};
        case (item.req_type)
            REQ_START:
            begin
                if (item.switch_on)
                begin
                    if (pause_on)
                        pause_on = 1'b0;
                    else
                        seq_run = RUN_WAIT_OBJ;
                    run_on = 1'b1;
                end
                else
                begin
                    run_on   = 1'b0;
                    pause_on = 1'b1;
                    stop_drives();
                    msg = MSG_PAUSED;
                end
            end
            REQ_CALIB:
            begin
                cal_on = item.switch_on;
                if (item.switch_on)
                begin
                    seq_cal   = CAL_BELT_ONE;
                    pulse_cnt = '0;
                end
            end
            REQ_SPEED:
            begin
                fast_on = item.switch_on;
                msg = item.switch_on ? MSG_FAST : MSG_SLOW;
            end
            default:
            begin
                // belt one sensor stop applies even during calibration
                if (seq_run == RUN_WAIT_OBJ && cube_here)
                    belt1 = 1'b0;
                if (cal_on)
                begin
                    case (seq_cal)
                        CAL_IDLE:
                            stop_drives();
                        CAL_BELT_ONE:
                        begin
                            if (pulse_cnt == '0)
                                msg = MSG_TEST_BELT1;
                            if (pulse_done(half, belt1))
                                seq_cal = CAL_BELT_TWO;
                        end
                        CAL_BELT_TWO:
                        begin
                            if (pulse_cnt == '0)
                                msg = MSG_TEST_BELT2;
                            if (pulse_done(half, belt2))
                                seq_cal = CAL_LEVER_OUT;
                        end
                        CAL_LEVER_OUT:
                        begin
                            msg   = MSG_TEST_OUT;
                            belt2 = 1'b0;
                            if (!fully_out)
                                lever = LEVER_FWD;
                            else
                            begin
                                lever   = LEVER_STOP;
                                seq_cal = CAL_LEVER_CHK;
                            end
                        end
                        CAL_LEVER_CHK:
                        begin
                            if (fully_out)
                                seq_cal = CAL_LEVER_IN;
                        end
                        CAL_LEVER_IN:
                        begin
                            msg = MSG_TEST_IN;
                            if (!at_home)
                                lever = LEVER_BACK;
                            else
                            begin
                                lever   = LEVER_STOP;
                                seq_cal = CAL_IDLE;
                                cal_on  = 1'b0;
                                msg     = MSG_CAL_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
                else if (run_on && !pause_on)
                begin
                    case (seq_run)
                        RUN_IDLE:
                            stop_drives();
                        RUN_WAIT_OBJ:
                        begin
                            if (cube_here)
                            begin
                                belt2   = 1'b1;
                                seq_run = RUN_PUSH;
                                msg     = MSG_DETECTED;
                            end
                            else
                            begin
                                belt1 = 1'b1;
                                belt2 = 1'b0;
                                lever = LEVER_STOP;
                            end
                        end
                        RUN_PUSH:
                        begin
                            if (!fully_out)
                            begin
                                lever = LEVER_FWD;
                                belt2 = 1'b1;
                            end
                            else
                            begin
                                lever   = LEVER_STOP;
                                seq_run = RUN_OUT;
                                msg     = MSG_XFER_OUT;
                            end
                        end
                        RUN_OUT:
                        begin
                            if (fully_out)
                            begin
                                seq_run = RUN_RETRACT;
                                msg     = MSG_MOVED;
                            end
                        end
                        RUN_RETRACT:
                        begin
                            if (!at_home)
                                lever = LEVER_BACK;
                            else
                            begin
                                lever = LEVER_STOP;
                                if (fast_on)
                                begin
                                    seq_run = RUN_WAIT_OBJ;
                                    msg     = MSG_IN_FAST;
                                end
                                else
                                begin
                                    seq_run = RUN_CARRY;
                                    msg     = MSG_XFER_IN;
                                end
                            end
                        end
                        RUN_CARRY:
                        begin
                            belt2 = 1'b1;
                            msg   = MSG_TRANSIT;
                            if (arrived)
                            begin
                                belt2   = 1'b0;
                                seq_run = RUN_WAIT_OBJ;
                                msg     = MSG_ARRIVED;
                            end
                        end
                        default: ;
                    endcase
                end
                else
                    stop_drives();
            end
        endcase
        res.belt_one_run = belt1;
        res.belt_two_run = belt2;
        res.lever_drive  = lever;
        res.run_step     = seq_run;
        res.calib_step   = seq_cal;
        res.message      = msg;
        return res;
    endfunction

    // Mostly scans whose sensor levels push the current step forward, with
    // switch events mixed in that pause, restart or abort the sequences.
    function automatic cts_item_t random_item();
        cts_item_t it;
        int        pick;
        it.req_type      = REQ_SCAN;
        it.switch_on     = 1'($urandom_range(0, 1));
        it.cube_at_start = 1'($urandom_range(0, 1));
        it.lever_home    = 1'($urandom_range(0, 1));
        it.lever_out     = 1'($urandom_range(0, 1));
        it.cube_at_end   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            it.req_type  = REQ_CALIB;
            it.switch_on = 1'b1;
        end
        else if (pick < 3)
        begin
            it.req_type  = REQ_CALIB;
            it.switch_on = 1'b0;
        end
        else if (pick < 6)
            it.req_type = REQ_SPEED;
        else if (pick < 8)
            it.req_type = REQ_START;
        else if (pick < 15 && (!run_on || pause_on))
        begin
            it.req_type  = REQ_START;
            it.switch_on = 1'b1;
        end
        else if (pick < 60)
        begin
            if (cal_on)
            begin
                case (seq_cal)
                    CAL_LEVER_OUT, CAL_LEVER_CHK: it.lever_out  = 1'b1;
                    CAL_LEVER_IN:                 it.lever_home = 1'b0;
                    default: ;
                endcase
            end
            else
            begin
                case (seq_run)
                    RUN_WAIT_OBJ:     it.cube_at_start = 1'b0;
                    RUN_PUSH, RUN_OUT: it.lever_out    = 1'b1;
                    RUN_RETRACT:      it.lever_home    = 1'b0;
                    RUN_CARRY:        it.cube_at_end   = 1'b0;
                    default: ;
                endcase
            end
        end
        return it;
    endfunction

    task automatic send_item(input cts_item_t item);
        int gap;
        if (tx_gaps)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 6);
                if (gap > 0)
                begin
                    @(negedge clk);
                    cmd_if.valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        @(negedge clk);
        cmd_if.valid         <= 1'b1;
        cmd_if.req_type      <= item.req_type;
        cmd_if.switch_on     <= item.switch_on;
        cmd_if.cube_at_start <= item.cube_at_start;
        cmd_if.lever_home    <= item.lever_home;
        cmd_if.lever_out     <= item.lever_out;
        cmd_if.cube_at_end   <= item.cube_at_end;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        status_forecast.push_back(next_status(item));
    endtask

    task automatic scan(input logic c_start, input logic home, input logic out,
                        input logic c_end);
        cts_item_t it;
        it.req_type      = REQ_SCAN;
        it.switch_on     = 1'b0;
        it.cube_at_start = c_start;
        it.lever_home    = home;
        it.lever_out     = out;
        it.cube_at_end   = c_end;
        send_item(it);
    endtask

    task automatic flip_switch(input req_type_t req, input logic on);
        cts_item_t it;
        it.req_type      = req;
        it.switch_on     = on;
        it.cube_at_start = 1'b1;
        it.lever_home    = 1'b0;
        it.lever_out     = 1'b0;
        it.cube_at_end   = 1'b1;
        send_item(it);
    endtask

    task automatic drain_results();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (status_forecast.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_pulse_ticks(input logic [15:0] value);
        drain_results();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        pulse_len = value;
    endtask

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Sensor levels are active low except lever_out: idle plant is 1, 0, 0, 1.
    task automatic test_run_sequence();
        scan(1, 0, 0, 1);
        flip_switch(REQ_START, 1'b1);
        scan(1, 0, 0, 1);
        scan(0, 0, 0, 1);
        scan(1, 1, 0, 1);
        scan(1, 1, 1, 1);
        scan(1, 1, 1, 1);
        scan(1, 1, 0, 1);
        scan(1, 0, 0, 1);
        scan(1, 0, 0, 1);
        flip_switch(REQ_START, 1'b0);
        scan(1, 0, 0, 0);
        flip_switch(REQ_START, 1'b1);
        scan(1, 0, 0, 0);
        flip_switch(REQ_SPEED, 1'b1);
        flip_switch(REQ_SPEED, 1'b0);
    endtask

    // Starts on the reset pulse length, then changes it mid pulse.
    task automatic test_pulse_extremes();
        flip_switch(REQ_CALIB, 1'b1);
        scan(1, 0, 0, 1);
        scan(1, 0, 0, 1);
        write_pulse_ticks(16'hFFFF);
        scan(1, 0, 0, 1);
        write_pulse_ticks(16'd1);
        scan(1, 0, 0, 1);
        flip_switch(REQ_CALIB, 1'b0);
    endtask

    // Zero length pulse runs as a one tick pulse.
    task automatic test_calibration();
        write_pulse_ticks(16'd0);
        flip_switch(REQ_CALIB, 1'b1);
        scan(1, 0, 0, 1);
        scan(0, 0, 0, 1);
        scan(1, 0, 0, 1);
        scan(1, 0, 0, 1);
        scan(1, 1, 0, 1);
        scan(1, 1, 1, 1);
        scan(1, 1, 1, 1);
        scan(0, 1, 0, 1);
        scan(1, 0, 0, 1);
    endtask

    task automatic test_backpressure();
        write_pulse_ticks(16'd2);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        hold_requests++;
        repeat (24) send_item(random_item());
        drain_results();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_pulse_ticks((phase == 0) ? 16'd1 : 16'($urandom_range(1, 5)));
            tx_gaps   = phase[0];
            rx_stalls = phase[1];
            repeat (PHASE_ITEMS) send_item(random_item());
        end
        drain_results();
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_data             = '0;
        cmd_if.valid         = 1'b0;
        cmd_if.req_type      = REQ_SCAN;
        cmd_if.switch_on     = 1'b0;
        cmd_if.cube_at_start = 1'b1;
        cmd_if.lever_home    = 1'b0;
        cmd_if.lever_out     = 1'b0;
        cmd_if.cube_at_end   = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_run_sequence();
        test_pulse_extremes();
        test_calibration();
        test_backpressure();
        test_random_traffic();

        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("conveyor_transfer_sequencer_test passed");
        else
            $display("conveyor_transfer_sequencer_test failed");
        $finish;
    end

    // Output side: random stall runs, or a long hold-off on request.
    initial
    begin : response_sink
        int   hold_left;
        int   run_left;
        int   holds_done;
        logic level;
        hold_left     = 0;
        run_left      = 0;
        holds_done    = 0;
        level         = 1'b1;
        rsp_if.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                level = 1'b0;
            end
            else if (!rx_stalls)
                level = 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    level    = ($urandom_range(0, 9) < 7);
                    run_left = $urandom_range(1, 6);
                end
                run_left--;
            end
            rsp_if.ready <= level;
        end
    end

    always @(posedge clk)
    begin
        cts_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (status_forecast.size() == 0)
            begin
                $error("rsp transaction with nothing outstanding");
                fails++;
            end
            else
            begin
                want = status_forecast.pop_front();
                check_field("belt_one_run", 4'(want.belt_one_run), 4'(rsp_if.belt_one_run));
                check_field("belt_two_run", 4'(want.belt_two_run), 4'(rsp_if.belt_two_run));
                check_field("lever_drive", 4'(want.lever_drive), 4'(rsp_if.lever_drive));
                check_field("run_step", 4'(want.run_step), 4'(rsp_if.run_step));
                check_field("calib_step", 4'(want.calib_step), 4'(rsp_if.calib_step));
                check_field("message", 4'(want.message), 4'(rsp_if.message));
            end
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("conveyor_transfer_sequencer_test failed");
        $finish;
    end

endmodule
